/* rtl/sample_voice_mixer_core_assert.svh */
// ----------------------------------------------------------------------------
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef SAMPLE_VOICE_MIXER_CORE_ASSERT_SVH
`define SAMPLE_VOICE_MIXER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SVM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("svm assertion failed");

// next-cycle implication, disabled during reset
`define SVM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("svm assertion failed");

// next-cycle implication that also holds across reset
`define SVM_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("svm assertion failed");

`endif

/* rtl/svm_pkg.sv */
// ----------------------------------------------------------------------------
// svm_pkg
// shared constants, codes and types of the sample voice mixer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package svm_pkg;

  localparam int NUM_VOICES   = 30;
  localparam int SAMPLE_DEPTH = 65536;

  localparam int ADDR_W   = $clog2(SAMPLE_DEPTH);
  localparam int VIDX_W   = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

  // word field widths
  localparam int OPCODE_W = 2;
  localparam int BASE_W   = 16;
  localparam int SAMPLE_W = 16;
  localparam int LEN_W    = 17;

  localparam int IN_BITS     = OPCODE_W + BASE_W + SAMPLE_W + LEN_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;

  // accumulator holds the worst-case sum of all voices
  localparam int SUM_W = SAMPLE_W + VIDX_W;

  typedef logic [VIDX_W-1:0] vidx_t;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_MIX   = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MIX,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // sequencer to voice table
  typedef struct packed {
    logic                start;
    logic                advance;
    vidx_t               idx;
    logic [BASE_W-1:0]   base;
    logic [LEN_W-1:0]    length;
  } voice_cmd_t;

  // voice table to sequencer
  typedef struct packed {
    logic                active;
    logic [ADDR_W-1:0]   addr;
  } voice_status_t;

endpackage

`default_nettype wire

/* rtl/svm_sample_ram.sv */
// ----------------------------------------------------------------------------
// svm_sample_ram
// single write, single read sample memory with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module svm_sample_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DATA_W-1:0]        wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/svm_voice_table.sv */
// ----------------------------------------------------------------------------
// svm_voice_table
// voice slots with one shared compare and address adder on the selected slot
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module svm_voice_table
  import svm_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire voice_cmd_t    cmd,
  output voice_status_t      status
);

  logic [BASE_W-1:0] base     [NUM_VOICES];
  logic [LEN_W-1:0]  length   [NUM_VOICES];
  logic [LEN_W-1:0]  position [NUM_VOICES];

  logic [BASE_W-1:0] sel_base;
  logic [LEN_W-1:0]  sel_len;
  logic [LEN_W-1:0]  sel_pos;

  assign sel_base = base[cmd.idx];
  assign sel_len  = length[cmd.idx];
  assign sel_pos  = position[cmd.idx];

  // slot plays while its position is below its length
  assign status.active = (sel_pos < sel_len);
  assign status.addr   = ADDR_W'(sel_base) + ADDR_W'(sel_pos);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      base[cmd.idx] <= cmd.base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_VOICES; i++) begin
        length[i]   <= '0;
        position[i] <= '0;
      end
    end else if (cmd.start) begin
      length[cmd.idx]   <= cmd.length;
      position[cmd.idx] <= '0;
    end else if (cmd.advance) begin
      position[cmd.idx] <= sel_pos + LEN_W'(1);
    end
  end

endmodule

`default_nettype wire

/* rtl/svm_mix_acc.sv */
// ----------------------------------------------------------------------------
// svm_mix_acc
// running sum of voice samples with saturation to the sample width
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module svm_mix_acc
  import svm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                clear,
  input  wire logic                add_en,
  input  wire logic [SAMPLE_W-1:0] sample,
  output logic      [SAMPLE_W-1:0] mixed
);

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sample_ext;
  logic             overflow;

  assign sample_ext = {{(SUM_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};

  always_ff @(posedge clk) begin
    if (clear) begin
      sum <= '0;
    end else if (add_en) begin
      sum <= sum + sample_ext;
    end
  end

  // out of range when the bits above the sample sign disagree
  assign overflow = (sum[SUM_W-1:SAMPLE_W-1] != {(SUM_W-SAMPLE_W+1){sum[SUM_W-1]}});

  always_comb begin
    if (!overflow) begin
      mixed = sum[SAMPLE_W-1:0];
    end else if (sum[SUM_W-1]) begin
      mixed = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      mixed = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

/* rtl/sample_voice_mixer_core.sv */
// ----------------------------------------------------------------------------
// sample_voice_mixer_core
// one-shot multi-voice sample mixer with saturating 16-bit output
// ----------------------------------------------------------------------------
// usage:
//   s_* carries command words: write a sample word, start a voice, or mix.
//   m_* carries one saturated mixed sample for every mix command.
// timing:
//   write word: stored in sample memory on accept, the block stays ready.
//   start voice: the shared slot compare examines the slots in turn;
//     stops at the first finished slot, or after the last slot.
//   mix: the sequencer walks every slot through the shared compare and
//     address adder, one slot per cycle, with one sample memory read per
//     cycle; the last sample is added in ST_DRAIN, the sum goes to the output
//     register in ST_EMIT, and the next word is taken back in ST_IDLE.
// reset: rst is synchronous; all slots become finished, the output register
//   empties. sample memory is not cleared and holds garbage until written.
// stall: the result waits in the output register; a new command can be
//   taken meanwhile, only a mix that finishes while it still waits holds
//   in its last state until the receiver takes the pending word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sample_voice_mixer_core
  import svm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // command word, lsb up: opcode[1:0], address[17:2], sample_value[33:18],
  // length[50:34], zero fill
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  // result word, lsb up: mixed_sample[15:0]
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic      [OUT_TDATA_W-1:0] m_tdata
);

  // command fields
  logic [OPCODE_W-1:0] in_opcode;
  logic [BASE_W-1:0]   in_address;
  logic [SAMPLE_W-1:0] in_sample;
  logic [LEN_W-1:0]    in_length;

  assign in_opcode  = s_tdata[OPCODE_W-1:0];
  assign in_address = s_tdata[OPCODE_W +: BASE_W];
  assign in_sample  = s_tdata[OPCODE_W+BASE_W +: SAMPLE_W];
  assign in_length  = s_tdata[OPCODE_W+BASE_W+SAMPLE_W +: LEN_W];

  state_t state, state_next;
  vidx_t  idx;
  logic   idx_last;
  logic   accept;

  // base and length of the last accepted word, used by a start command
  logic [BASE_W-1:0] start_base;
  logic [LEN_W-1:0]  start_len;

  // slot read in the previous cycle had a sample in flight from memory
  logic active_d;

  voice_cmd_t    vcmd;
  voice_status_t vstat;

  logic [SAMPLE_W-1:0] ram_rdata;
  logic                ram_we;
  logic                acc_clear;
  logic                acc_add;
  logic [SAMPLE_W-1:0] mixed;
  logic                out_free;

  assign accept   = s_tvalid && s_tready;
  assign idx_last = (idx == VIDX_W'(NUM_VOICES - 1));
  assign out_free = !m_tvalid || m_tready;

  // ---------------- datapath parts ----------------

  svm_sample_ram #(
    .DATA_W (SAMPLE_W),
    .DEPTH  (SAMPLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(in_address)),
    .wdata (in_sample),
    .raddr (vstat.addr),
    .rdata (ram_rdata)
  );

  svm_voice_table u_table (
    .clk    (clk),
    .rst    (rst),
    .cmd    (vcmd),
    .status (vstat)
  );

  svm_mix_acc u_acc (
    .clk    (clk),
    .clear  (acc_clear),
    .add_en (acc_add),
    .sample (ram_rdata),
    .mixed  (mixed)
  );

  // ---------------- sequencer ----------------

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (in_opcode)
            OP_START: state_next = ST_SCAN;
            OP_MIX:   state_next = ST_MIX;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        // first finished slot takes the sound, no free slot drops it
        if (!vstat.active || idx_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_MIX: begin
        if (idx_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready     = (state == ST_IDLE);
    ram_we       = accept && (in_opcode == OP_WRITE);
    acc_clear    = accept;
    acc_add      = ((state == ST_MIX) || (state == ST_DRAIN)) && active_d;
    vcmd.idx     = idx;
    vcmd.base    = start_base;
    vcmd.length  = start_len;
    vcmd.start   = (state == ST_SCAN) && !vstat.active;
    vcmd.advance = (state == ST_MIX) && vstat.active;
  end

  // slot counter and pipeline flag
  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      active_d <= 1'b0;
    end else if (accept) begin
      idx      <= '0;
      active_d <= 1'b0;
    end else begin
      active_d <= (state == ST_MIX) && vstat.active;
      if (((state == ST_SCAN) || (state == ST_MIX)) && !idx_last) begin
        idx <= idx + VIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      start_base <= in_address;
      start_len  <= in_length;
    end
  end

  // ---------------- output register ----------------

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_EMIT) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_EMIT) && out_free) begin
      m_tdata <= OUT_TDATA_W'(mixed);
    end
  end

endmodule

`default_nettype wire

/* rtl/svm_checker.sv */
// ----------------------------------------------------------------------------
// svm_checker
// port-level checks of the sample voice mixer, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sample_voice_mixer_core_assert.svh"

module svm_checker
  import svm_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_tvalid,
  input wire logic                   s_tready,
  input wire logic [IN_TDATA_W-1:0]  s_tdata,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready,
  input wire logic [OUT_TDATA_W-1:0] m_tdata
);

  logic acc_word;
  logic write_word;
  logic mix_word;

  assign acc_word   = s_tvalid && s_tready;
  assign write_word = acc_word && (s_tdata[OPCODE_W-1:0] == OP_WRITE);
  assign mix_word   = acc_word && (s_tdata[OPCODE_W-1:0] == OP_MIX);

  // output register empties on reset
  `SVM_ASSERT_ALWAYS(a_rst_empty, clk, rst, !m_tvalid)

  // stalled result holds
  `SVM_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // a sample write never blocks the next word
  `SVM_ASSERT_NEXT(a_write_ready, clk, rst, write_word, s_tready)

  // the input closes after a mix word is taken
  `SVM_ASSERT_NEXT(a_mix_busy, clk, rst, mix_word, !s_tready)

  // no result can appear right after a mix is taken with an empty output
  `SVM_ASSERT_NEXT(a_no_early_out, clk, rst, mix_word && !m_tvalid, !m_tvalid)

endmodule

bind sample_voice_mixer_core svm_checker u_svm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
